/* rtl/crls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crls_pkg
// Shared types and constants of the chunk residency unit: table geometry,
// command and status codes, register indexes and the per-slot record.
// ----------------------------------------------------------------------------
package crls_pkg;

   localparam int SLOTS = 32;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_TOUCH = 2'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_EMPTY        = 3'd1;
   localparam logic [2:0] ST_UNKNOWN      = 3'd2;
   localparam logic [2:0] ST_FULL         = 3'd3;
   localparam logic [2:0] ST_BUDGET_UNMET = 3'd4;

   localparam logic CSR_MAX_RESIDENT = 1'b0;
   localparam logic CSR_SPILL_ENABLE = 1'b1;

   typedef struct packed {
      logic        resident;
      logic [47:0] frame;
      logic [23:0] size;
      logic [39:0] offset;
   } rec_type;

   typedef struct packed {
      logic    rd_en;
      idx_type rd_addr;
      logic    wr_en;
      idx_type wr_addr;
      rec_type wr_rec;
   } mem_req_type;

   typedef struct packed {
      logic    restart;
      logic    issue;
      idx_type issue_idx;
   } scan_ctl_type;

   typedef struct packed {
      logic        pend;
      logic        valid;
      idx_type     idx;
      logic [47:0] frame;
      logic [23:0] size;
   } victim_type;

endpackage
`default_nettype wire

/* rtl/crls_slot_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crls_slot_mem
// Slot record memory: one write port and one read port, read data
// registered, so a read returns its record in the cycle after it is issued.
// ----------------------------------------------------------------------------
module crls_slot_mem (
   input  wire                   clock,
   input  crls_pkg::mem_req_type req,
   output crls_pkg::rec_type     rd_rec
);

   crls_pkg::rec_type slot_mem [crls_pkg::SLOTS];
   crls_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         slot_mem[req.wr_addr] <= req.wr_rec;
      end
      if (req.rd_en) begin
         rd_data_ff <= slot_mem[req.rd_addr];
      end
   end

   assign rd_rec = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/crls_victim_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crls_victim_scan
// Tracks the oldest resident slot while slot records stream out of the
// memory in ascending order; the earliest slot wins equal frame stamps.
// ----------------------------------------------------------------------------
module crls_victim_scan (
   input  wire                    clock,
   input  wire                    reset,
   input  crls_pkg::scan_ctl_type ctl,
   input  crls_pkg::rec_type      rd_rec,
   output crls_pkg::victim_type   victim
);

   logic              pend_ff;
   crls_pkg::idx_type rd_idx_ff;
   logic              valid_ff;
   logic              valid_in;
   crls_pkg::idx_type best_idx_ff;
   crls_pkg::idx_type best_idx_in;
   logic [47:0]       best_frame_ff;
   logic [47:0]       best_frame_in;
   logic [23:0]       best_size_ff;
   logic [23:0]       best_size_in;
   logic              take;

   assign take = pend_ff && rd_rec.resident && (!valid_ff || (rd_rec.frame < best_frame_ff));

   always_comb begin
      valid_in      = valid_ff;
      best_idx_in   = best_idx_ff;
      best_frame_in = best_frame_ff;
      best_size_in  = best_size_ff;
      if (ctl.restart) begin
         valid_in = 1'b0;
      end else if (take) begin
         valid_in      = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_frame_in = rd_rec.frame;
         best_size_in  = rd_rec.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= ctl.issue;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= ctl.issue_idx;
      best_idx_ff   <= best_idx_in;
      best_frame_ff <= best_frame_in;
      best_size_ff  <= best_size_in;
   end

   assign victim.pend  = pend_ff;
   assign victim.valid = valid_ff;
   assign victim.idx   = best_idx_ff;
   assign victim.frame = best_frame_ff;
   assign victim.size  = best_size_ff;

endmodule
`default_nettype wire

/* rtl/chunk_residency_lru_spill_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_residency_lru_spill_unit
// Residency manager for numbered chunks with oldest-frame spilling.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; the unit then works
// on it alone. Results cannot be stalled: each is shown for one cycle with
// rsp_strobe, spill results first and the final result (rsp_last) at the end,
// and the final strobe shows in the cycle busy falls, so a new command may be
// started then. A command that reads a slot record passes through S_MOD
// before S_PLAN and S_FINAL, and each spill adds a pass of S_SCAN: every
// spill scans the slot records of all chunks added so far through the single
// read port of the slot memory, one per cycle. Memory reads and writes are
// sequenced so that they never overlap. Configuration writes are taken at any
// time and must only be made while the unit is idle.
// ----------------------------------------------------------------------------
module chunk_residency_lru_spill_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_command,
   input  wire  [5:0]  req_chunk_id,
   input  wire  [47:0] req_frame,
   input  wire  [23:0] req_payload_bytes,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_id,
   output logic [28:0] rsp_logical_offset,
   output logic        rsp_evict_valid,
   output logic [5:0]  rsp_evict_slot,
   output logic [39:0] rsp_store_offset,
   output logic [23:0] rsp_transfer_bytes,
   output logic        rsp_reloaded,
   output logic [5:0]  rsp_resident_count,
   output logic        rsp_budget_ok,
   output logic        rsp_last,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [5:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOD   = 3'd1;
   localparam logic [2:0] S_PLAN  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [5:0]        max_ff, max_in;
   logic              spill_en_ff, spill_en_in;
   crls_pkg::cnt_type used_ff, used_in;
   crls_pkg::cnt_type res_ff, res_in;
   logic [39:0]       append_ff, append_in;
   logic [28:0]       payload_ff, payload_in;
   crls_pkg::cnt_type spill_left_ff, spill_left_in;
   crls_pkg::cnt_type issue_ff, issue_in;
   logic              enforce_ff, enforce_in;
   logic              budget_ff, budget_in;

   logic [1:0]        cmd_ff, cmd_in;
   logic [47:0]       frame_ff, frame_in;
   logic [23:0]       bytes_ff, bytes_in;
   crls_pkg::idx_type cur_idx_ff, cur_idx_in;
   logic [2:0]        status_ff, status_in;
   logic [5:0]        slot_out_ff, slot_out_in;
   logic [28:0]       logical_ff, logical_in;
   logic              reloaded_ff, reloaded_in;
   logic [39:0]       rl_off_ff, rl_off_in;
   logic [23:0]       rl_len_ff, rl_len_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_evict_valid_ff, rsp_evict_valid_in;
   logic [5:0]        rsp_evict_slot_ff, rsp_evict_slot_in;
   logic [39:0]       rsp_store_offset_ff, rsp_store_offset_in;
   logic [23:0]       rsp_transfer_bytes_ff, rsp_transfer_bytes_in;
   logic              rsp_last_ff, rsp_last_in;

   crls_pkg::mem_req_type  mem_req;
   crls_pkg::rec_type      rd_rec;
   crls_pkg::rec_type      new_rec;
   crls_pkg::scan_ctl_type scan_ctl;
   crls_pkg::victim_type   victim;

   logic              known;
   crls_pkg::idx_type req_idx;
   logic              over;
   crls_pkg::cnt_type spill_n;
   crls_pkg::cnt_type fin_res;

   crls_slot_mem u_mem (
      .clock  (clock),
      .req    (mem_req),
      .rd_rec (rd_rec)
   );

   crls_victim_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctl    (scan_ctl),
      .rd_rec (rd_rec),
      .victim (victim)
   );

   assign known   = (req_chunk_id != 6'd0) && (8'(req_chunk_id) <= 8'(used_ff));
   assign req_idx = crls_pkg::idx_type'(req_chunk_id - 6'd1);
   assign over    = enforce_ff && spill_en_ff && (max_ff != 6'd0) && (8'(res_ff) > 8'(max_ff));
   assign spill_n = over ? crls_pkg::cnt_type'(8'(res_ff) - 8'(max_ff)) : '0;
   assign fin_res = res_ff - spill_n;

   always_comb begin
      state_in      = state_ff;
      max_in        = max_ff;
      spill_en_in   = spill_en_ff;
      used_in       = used_ff;
      res_in        = res_ff;
      append_in     = append_ff;
      payload_in    = payload_ff;
      spill_left_in = spill_left_ff;
      issue_in      = issue_ff;
      enforce_in    = enforce_ff;
      budget_in     = budget_ff;
      cmd_in        = cmd_ff;
      frame_in      = frame_ff;
      bytes_in      = bytes_ff;
      cur_idx_in    = cur_idx_ff;
      status_in     = status_ff;
      slot_out_in   = slot_out_ff;
      logical_in    = logical_ff;
      reloaded_in   = reloaded_ff;
      rl_off_in     = rl_off_ff;
      rl_len_in     = rl_len_ff;

      rsp_strobe_in         = 1'b0;
      rsp_evict_valid_in    = rsp_evict_valid_ff;
      rsp_evict_slot_in     = rsp_evict_slot_ff;
      rsp_store_offset_in   = rsp_store_offset_ff;
      rsp_transfer_bytes_in = rsp_transfer_bytes_ff;
      rsp_last_in           = rsp_last_ff;

      mem_req  = '0;
      scan_ctl = '0;
      new_rec  = rd_rec;

      if (csr_we) begin
         if (csr_index == crls_pkg::CSR_MAX_RESIDENT) begin
            max_in = csr_wdata;
         end else begin
            spill_en_in = csr_wdata[0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_command;
               frame_in    = req_frame;
               bytes_in    = req_payload_bytes;
               cur_idx_in  = req_idx;
               status_in   = crls_pkg::ST_OK;
               slot_out_in = req_chunk_id;
               logical_in  = '0;
               reloaded_in = 1'b0;
               rl_off_in   = '0;
               rl_len_in   = '0;
               enforce_in  = 1'b0;
               state_in    = S_PLAN;
               priority if (req_command == crls_pkg::CMD_ADD) begin
                  slot_out_in = '0;
                  priority if (req_payload_bytes == 24'd0) begin
                     status_in = crls_pkg::ST_EMPTY;
                  end else if (used_ff >= crls_pkg::cnt_type'(crls_pkg::SLOTS)) begin
                     status_in = crls_pkg::ST_FULL;
                  end else begin
                     mem_req.wr_en           = 1'b1;
                     mem_req.wr_addr         = crls_pkg::idx_type'(used_ff);
                     mem_req.wr_rec.resident = 1'b1;
                     mem_req.wr_rec.frame    = req_frame;
                     mem_req.wr_rec.size     = req_payload_bytes;
                     mem_req.wr_rec.offset   = '0;
                     used_in     = used_ff + crls_pkg::cnt_type'(1);
                     slot_out_in = 6'(used_ff + crls_pkg::cnt_type'(1));
                     logical_in  = payload_ff;
                     payload_in  = 29'(payload_ff + 29'(req_payload_bytes));
                     res_in      = res_ff + crls_pkg::cnt_type'(1);
                     enforce_in  = 1'b1;
                  end
               end else if (req_command == crls_pkg::CMD_WRITE &&
                            req_payload_bytes == 24'd0) begin
                  status_in = crls_pkg::ST_EMPTY;
               end else if (!known) begin
                  status_in = crls_pkg::ST_UNKNOWN;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = req_idx;
                  state_in        = S_MOD;
               end
            end
         end
         S_MOD: begin
            new_rec.frame = frame_ff;
            if (cmd_ff != crls_pkg::CMD_TOUCH) begin
               enforce_in = 1'b1;
               if (!rd_rec.resident) begin
                  new_rec.resident = 1'b1;
                  res_in      = res_ff + crls_pkg::cnt_type'(1);
                  reloaded_in = 1'b1;
                  rl_off_in   = rd_rec.offset;
                  rl_len_in   = rd_rec.size;
               end
               if (cmd_ff == crls_pkg::CMD_WRITE) begin
                  payload_in   = 29'(payload_ff - 29'(rd_rec.size) + 29'(bytes_ff));
                  new_rec.size = bytes_ff;
               end
            end
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_idx_ff;
            mem_req.wr_rec  = new_rec;
            state_in        = S_PLAN;
         end
         S_PLAN: begin
            res_in        = fin_res;
            budget_in     = (max_ff == 6'd0) || (8'(fin_res) <= 8'(max_ff));
            spill_left_in = spill_n;
            if (enforce_ff && cmd_ff == crls_pkg::CMD_WRITE &&
                !((max_ff == 6'd0) || (8'(fin_res) <= 8'(max_ff)))) begin
               status_in = crls_pkg::ST_BUDGET_UNMET;
            end
            if (over) begin
               scan_ctl.restart = 1'b1;
               issue_in         = '0;
               state_in         = S_SCAN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_SCAN: begin
            if (issue_ff != used_ff) begin
               mem_req.rd_en      = 1'b1;
               mem_req.rd_addr    = crls_pkg::idx_type'(issue_ff);
               scan_ctl.issue     = 1'b1;
               scan_ctl.issue_idx = crls_pkg::idx_type'(issue_ff);
               issue_in           = issue_ff + crls_pkg::cnt_type'(1);
            end else if (!victim.pend) begin
               mem_req.wr_en           = 1'b1;
               mem_req.wr_addr         = victim.idx;
               mem_req.wr_rec.resident = 1'b0;
               mem_req.wr_rec.frame    = victim.frame;
               mem_req.wr_rec.size     = victim.size;
               mem_req.wr_rec.offset   = append_ff;
               rsp_strobe_in         = 1'b1;
               rsp_evict_valid_in    = 1'b1;
               rsp_evict_slot_in     = 6'(crls_pkg::cnt_type'(victim.idx) +
                                          crls_pkg::cnt_type'(1));
               rsp_store_offset_in   = append_ff;
               rsp_transfer_bytes_in = victim.size;
               rsp_last_in           = 1'b0;
               append_in     = 40'(append_ff + 40'(victim.size));
               spill_left_in = spill_left_ff - crls_pkg::cnt_type'(1);
               if (spill_left_ff == crls_pkg::cnt_type'(1)) begin
                  state_in = S_FINAL;
               end else begin
                  issue_in         = '0;
                  scan_ctl.restart = 1'b1;
               end
            end
         end
         S_FINAL: begin
            rsp_strobe_in         = 1'b1;
            rsp_evict_valid_in    = 1'b0;
            rsp_evict_slot_in     = '0;
            rsp_store_offset_in   = rl_off_ff;
            rsp_transfer_bytes_in = rl_len_ff;
            rsp_last_in           = 1'b1;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_ff        <= '0;
         spill_en_ff   <= 1'b1;
         used_ff       <= '0;
         res_ff        <= '0;
         append_ff     <= '0;
         payload_ff    <= '0;
         spill_left_ff <= '0;
         issue_ff      <= '0;
         enforce_ff    <= 1'b0;
         budget_ff     <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_ff        <= max_in;
         spill_en_ff   <= spill_en_in;
         used_ff       <= used_in;
         res_ff        <= res_in;
         append_ff     <= append_in;
         payload_ff    <= payload_in;
         spill_left_ff <= spill_left_in;
         issue_ff      <= issue_in;
         enforce_ff    <= enforce_in;
         budget_ff     <= budget_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff                <= cmd_in;
      frame_ff              <= frame_in;
      bytes_ff              <= bytes_in;
      cur_idx_ff            <= cur_idx_in;
      status_ff             <= status_in;
      slot_out_ff           <= slot_out_in;
      logical_ff            <= logical_in;
      reloaded_ff           <= reloaded_in;
      rl_off_ff             <= rl_off_in;
      rl_len_ff             <= rl_len_in;
      rsp_evict_valid_ff    <= rsp_evict_valid_in;
      rsp_evict_slot_ff     <= rsp_evict_slot_in;
      rsp_store_offset_ff   <= rsp_store_offset_in;
      rsp_transfer_bytes_ff <= rsp_transfer_bytes_in;
      rsp_last_ff           <= rsp_last_in;
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_slot_id        = slot_out_ff;
   assign rsp_logical_offset = logical_ff;
   assign rsp_evict_valid    = rsp_evict_valid_ff;
   assign rsp_evict_slot     = rsp_evict_slot_ff;
   assign rsp_store_offset   = rsp_store_offset_ff;
   assign rsp_transfer_bytes = rsp_transfer_bytes_ff;
   assign rsp_reloaded       = reloaded_ff;
   assign rsp_resident_count = 6'(res_ff);
   assign rsp_budget_ok      = budget_ff;
   assign rsp_last           = rsp_last_ff;

   a_mem_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("slot memory read and written in the same cycle");

   a_final_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("final transaction shown while still busy");

   a_res_bounded: assert property (@(posedge clock) disable iff (reset)
      res_ff <= used_ff)
      else $error("resident count exceeds number of chunks");

   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (spill_left_ff != '0 && used_ff != '0))
      else $error("victim scan running with no spill pending");

   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && issue_ff == used_ff && !victim.pend) |-> victim.valid)
      else $error("spill issued without a resident victim");

endmodule
`default_nettype wire
